### sv/pfr_pkg.sv
package pfr_pkg;

    // request function codes
    localparam logic [1:0] FN_INSERT    = 2'd0;
    localparam logic [1:0] FN_LOOKUP    = 2'd1;
    localparam logic [1:0] FN_SET_FLAGS = 2'd2;

    // register indexes on the config port
    localparam logic REG_POLICY   = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    // replacement policy values
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam logic [4:0] CAPACITY_RESET = 5'd16;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_HIT      = 3'd2,
        ST_MISS     = 3'd3,
        ST_REFUSED  = 3'd4
    } t_status;

    // compare unit operating mode
    typedef enum logic {
        CM_SCAN = 1'b0,
        CM_DROP = 1'b1
    } t_cmp_mode;

    typedef struct packed {
        logic        tag_match;
        logic        victim_better;
        logic        age_above;
    } t_cmp_flags;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] page_number;
        logic [7:0]  pin_value;
        logic        dirty_value;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [3:0]  slot;
        logic        evicted_valid;
        logic [15:0] evicted_page;
        logic        writeback;
    } t_rsp;

endpackage

### sv/pfr_if.sv
interface pfr_req_if import pfr_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pfr_rsp_if import pfr_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### sv/pfr_frame_mem.sv
module pfr_frame_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 29
) (
    input  logic                     i_clk,
    input  logic                     i_wen,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_ren,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ren) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/pfr_cmp_unit.sv
module pfr_cmp_unit import pfr_pkg::*; #(
    parameter int PW = 16,
    parameter int AW = 4,
    parameter int IW = 4
) (
    input  t_cmp_mode     i_mode,
    input  logic          i_entry_valid,
    input  logic [PW-1:0] i_tag,
    input  logic [PW-1:0] i_page,
    input  logic [7:0]    i_pin,
    input  logic [AW-1:0] i_age,
    input  logic          i_best_found,
    input  logic [AW-1:0] i_best_age,
    input  logic [IW-1:0] i_idx,
    input  logic [IW-1:0] i_drop_s,
    input  logic [AW-1:0] i_drop_r,
    output t_cmp_flags    o_flags
);

    logic [AW-1:0] w_op_a;
    logic [AW-1:0] w_op_b;
    logic          w_lt;

    // one magnitude comparator: age < best during scan, rank < age during drop
    always_comb begin
        unique case (i_mode)
            CM_DROP: begin
                w_op_a = i_drop_r;
                w_op_b = i_age;
            end
            default: begin
                w_op_a = i_age;
                w_op_b = i_best_age;
            end
        endcase
    end

    assign w_lt = (w_op_a < w_op_b);

    assign o_flags.tag_match     = i_entry_valid && (i_tag == i_page);
    assign o_flags.victim_better = i_entry_valid && (i_pin == 8'd0) &&
                                   (!i_best_found || w_lt);
    assign o_flags.age_above     = i_entry_valid && (i_idx != i_drop_s) && w_lt;

endmodule

### sv/page_frame_replacement.sv
// Page-frame replacement table with pinning, FIFO or LRU order.
// Request channel i_req carries func, page_number, pin_value and dirty_value;
// response channel o_rsp returns status, slot, evicted_valid, evicted_page
// and writeback, exactly one response per request, in order.
// The APB port holds policy (0x0) and capacity (0x4); write them while idle.
// Each request sweeps the frame memory through its single read port, one
// frame per cycle, with a shared compare unit judging tag match, victim
// age and rank shift. After the scan sweep, misses, refusals, duplicate
// inserts and FIFO lookup hits respond directly; plain inserts and
// set-flags hits first write the frame; an evicting insert or an LRU lookup
// hit runs a second sweep to close the rank gap, then writes the frame.
// One request is in flight at a time; the next is taken in the cycle after the
// response is registered, even while that response still waits on
// o_rsp.ready; no new request is taken before that.
// A stalled receiver holds the response and, after the following request
// completes its sweep, holds that one in the sequencer.
// Reset (synchronous, active low) clears all valid bits, policy to FIFO and
// capacity to 16; no clearing pass is needed.
module page_frame_replacement import pfr_pkg::*; #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfr_req_if.sink     i_req,
    pfr_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW   = PAGE_BITS;
    localparam int IW   = $clog2(FRAMES);
    localparam int AW   = IW;
    localparam int CNTW = $clog2(FRAMES + 1);
    localparam int CAPW = (CNTW > 5) ? CNTW : 5;
    localparam int EW   = PW + 8 + 1 + AW;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_DROP   = 6'b001000,
        S_WRITE  = 6'b010000,
        S_RESP   = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic              r_policy;
    logic [4:0]        r_capacity;
    t_req              r_req, n_req;
    logic [CNTW-1:0]   r_cnt, n_cnt;
    logic              r_rd_live;
    logic [IW-1:0]     r_rd_idx;
    logic [FRAMES-1:0] r_valid, n_valid;
    logic [CNTW-1:0]   r_count, n_count;

    logic              r_hit_found, n_hit_found;
    logic [IW-1:0]     r_hit_idx, n_hit_idx;
    logic [7:0]        r_hit_pin, n_hit_pin;
    logic              r_hit_dirty, n_hit_dirty;
    logic [AW-1:0]     r_hit_age, n_hit_age;

    logic              r_vic_found, n_vic_found;
    logic [IW-1:0]     r_vic_idx, n_vic_idx;
    logic [AW-1:0]     r_vic_age, n_vic_age;
    logic [PW-1:0]     r_vic_tag, n_vic_tag;
    logic              r_vic_dirty, n_vic_dirty;

    logic              r_free_found, n_free_found;
    logic [IW-1:0]     r_free_idx, n_free_idx;

    logic [IW-1:0]     r_drop_s, n_drop_s;
    logic [AW-1:0]     r_drop_r, n_drop_r;
    logic [IW-1:0]     r_new_slot, n_new_slot;
    logic [EW-1:0]     r_new_entry, n_new_entry;
    logic              r_new_ins, n_new_ins;

    t_rsp              r_rsp, n_rsp;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_out, n_out;

    logic [31:0]       w_page_ext;
    logic [PW-1:0]     w_page;
    logic              w_ren;
    logic              w_wen;
    logic [IW-1:0]     w_waddr;
    logic [EW-1:0]     w_wdata;
    logic [EW-1:0]     w_rdata;
    logic [PW-1:0]     w_rd_tag;
    logic [7:0]        w_rd_pin;
    logic              w_rd_dirty;
    logic [AW-1:0]     w_rd_age;
    logic              w_ent_valid;
    logic              w_pass_done;
    t_cmp_mode         w_mode;
    t_cmp_flags        w_flags;
    logic [CAPW-1:0]   w_cap_raw;
    logic [CAPW-1:0]   w_cap;
    logic              w_full;
    logic [CNTW-1:0]   w_cnt_m1;
    logic [31:0]       w_vic_tag_ext;
    logic              w_reg_idx;
    logic              w_cfg_wr;

    // page number reduced to the tag width
    assign w_page_ext = 32'(r_req.page_number);
    assign w_page     = w_page_ext[PW-1:0];

    // frame entry fields: {tag, pin, dirty, age}
    assign w_rd_age   = w_rdata[AW-1:0];
    assign w_rd_dirty = w_rdata[AW];
    assign w_rd_pin   = w_rdata[AW+8:AW+1];
    assign w_rd_tag   = w_rdata[EW-1:AW+9];
    assign w_ent_valid = r_valid[r_rd_idx];

    assign w_pass_done = (r_cnt == CNTW'(FRAMES)) && !r_rd_live;
    assign w_ren = (r_state == S_SCAN || r_state == S_DROP) && (r_cnt != CNTW'(FRAMES));
    assign w_mode = (r_state == S_DROP) ? CM_DROP : CM_SCAN;

    // capacity clamped to 1..FRAMES
    assign w_cap_raw = CAPW'(r_capacity);
    always_comb begin
        if (w_cap_raw == '0) begin
            w_cap = CAPW'(1);
        end else if (w_cap_raw > CAPW'(FRAMES)) begin
            w_cap = CAPW'(FRAMES);
        end else begin
            w_cap = w_cap_raw;
        end
    end
    assign w_full   = (CAPW'(r_count) >= w_cap);
    assign w_cnt_m1 = r_count - CNTW'(1);
    assign w_vic_tag_ext = 32'(r_vic_tag);

    // memory write: rank shift during drop sweep, final entry in write state
    assign w_wen   = (r_state == S_WRITE) ||
                     ((r_state == S_DROP) && r_rd_live && w_flags.age_above);
    assign w_waddr = (r_state == S_WRITE) ? r_new_slot : r_rd_idx;
    assign w_wdata = (r_state == S_WRITE) ? r_new_entry :
                     {w_rd_tag, w_rd_pin, w_rd_dirty, w_rd_age - AW'(1)};

    pfr_frame_mem #(
        .DEPTH (FRAMES),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_wen   (w_wen),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_ren   (w_ren),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (w_rdata)
    );

    pfr_cmp_unit #(
        .PW (PW),
        .AW (AW),
        .IW (IW)
    ) u_cmp (
        .i_mode        (w_mode),
        .i_entry_valid (w_ent_valid),
        .i_tag         (w_rd_tag),
        .i_page        (w_page),
        .i_pin         (w_rd_pin),
        .i_age         (w_rd_age),
        .i_best_found  (r_vic_found),
        .i_best_age    (r_vic_age),
        .i_idx         (r_rd_idx),
        .i_drop_s      (r_drop_s),
        .i_drop_r      (r_drop_r),
        .o_flags       (w_flags)
    );

    // config port
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (w_reg_idx)
            REG_POLICY:   prdata = 32'(r_policy);
            REG_CAPACITY: prdata = 32'(r_capacity);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= POLICY_FIFO;
            r_capacity <= CAPACITY_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_POLICY:   r_policy   <= pwdata[0];
                REG_CAPACITY: r_capacity <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // handshakes
    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_cnt        = r_cnt;
        n_valid      = r_valid;
        n_count      = r_count;
        n_hit_found  = r_hit_found;
        n_hit_idx    = r_hit_idx;
        n_hit_pin    = r_hit_pin;
        n_hit_dirty  = r_hit_dirty;
        n_hit_age    = r_hit_age;
        n_vic_found  = r_vic_found;
        n_vic_idx    = r_vic_idx;
        n_vic_age    = r_vic_age;
        n_vic_tag    = r_vic_tag;
        n_vic_dirty  = r_vic_dirty;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_drop_s     = r_drop_s;
        n_drop_r     = r_drop_r;
        n_new_slot   = r_new_slot;
        n_new_entry  = r_new_entry;
        n_new_ins    = r_new_ins;
        n_rsp        = r_rsp;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !o_rsp.ready;

        if (w_ren) begin
            n_cnt = r_cnt + CNTW'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req        = i_req.payload;
                    n_cnt        = '0;
                    n_hit_found  = 1'b0;
                    n_vic_found  = 1'b0;
                    n_free_found = 1'b0;
                    n_state      = S_SCAN;
                end
            end

            // one frame per cycle: match, oldest unpinned, first free
            S_SCAN: begin
                if (r_rd_live) begin
                    if (!w_ent_valid && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_rd_idx;
                    end
                    if (w_flags.tag_match && !r_hit_found) begin
                        n_hit_found = 1'b1;
                        n_hit_idx   = r_rd_idx;
                        n_hit_pin   = w_rd_pin;
                        n_hit_dirty = w_rd_dirty;
                        n_hit_age   = w_rd_age;
                    end
                    if (w_flags.victim_better) begin
                        n_vic_found = 1'b1;
                        n_vic_idx   = r_rd_idx;
                        n_vic_age   = w_rd_age;
                        n_vic_tag   = w_rd_tag;
                        n_vic_dirty = w_rd_dirty;
                    end
                end
                if (w_pass_done) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_rsp        = '0;
                n_rsp.status = ST_MISS;
                n_new_ins    = 1'b0;
                n_cnt        = '0;
                n_state      = S_RESP;
                unique case (r_req.func)
                    FN_INSERT: begin
                        if (r_hit_found) begin
                            n_rsp.status = ST_PRESENT;
                            n_rsp.slot   = 4'(r_hit_idx);
                        end else if (w_full) begin
                            if (!r_vic_found) begin
                                n_rsp.status = ST_REFUSED;
                            end else begin
                                // evict the victim, then insert in the lowest free slot
                                n_rsp.status        = ST_INSERTED;
                                n_rsp.evicted_valid = 1'b1;
                                n_rsp.evicted_page  = w_vic_tag_ext[15:0];
                                n_rsp.writeback     = r_vic_dirty;
                                n_valid[r_vic_idx]  = 1'b0;
                                n_count             = w_cnt_m1;
                                n_drop_s            = r_vic_idx;
                                n_drop_r            = r_vic_age;
                                n_new_slot = (r_free_found && (r_free_idx < r_vic_idx)) ?
                                             r_free_idx : r_vic_idx;
                                n_rsp.slot  = 4'(n_new_slot);
                                n_new_entry = {w_page, 8'd0, 1'b0, w_cnt_m1[AW-1:0]};
                                n_new_ins   = 1'b1;
                                n_state     = S_DROP;
                            end
                        end else if (r_free_found) begin
                            n_rsp.status = ST_INSERTED;
                            n_rsp.slot   = 4'(r_free_idx);
                            n_new_slot   = r_free_idx;
                            n_new_entry  = {w_page, 8'd0, 1'b0, r_count[AW-1:0]};
                            n_new_ins    = 1'b1;
                            n_state      = S_WRITE;
                        end else begin
                            n_rsp.status = ST_REFUSED;
                        end
                    end
                    FN_LOOKUP: begin
                        if (r_hit_found) begin
                            n_rsp.status = ST_HIT;
                            n_rsp.slot   = 4'(r_hit_idx);
                            if (r_policy == POLICY_LRU) begin
                                // move to the most recent end
                                n_drop_s    = r_hit_idx;
                                n_drop_r    = r_hit_age;
                                n_new_slot  = r_hit_idx;
                                n_new_entry = {w_page, r_hit_pin, r_hit_dirty,
                                               w_cnt_m1[AW-1:0]};
                                n_state     = S_DROP;
                            end
                        end
                    end
                    FN_SET_FLAGS: begin
                        if (r_hit_found) begin
                            n_rsp.status = ST_INSERTED;
                            n_rsp.slot   = 4'(r_hit_idx);
                            n_new_slot   = r_hit_idx;
                            n_new_entry  = {w_page, r_req.pin_value, r_req.dirty_value,
                                            r_hit_age};
                            n_state      = S_WRITE;
                        end
                    end
                    default: ;
                endcase
            end

            // close the rank gap left by the dropped frame
            S_DROP: begin
                if (w_pass_done) begin
                    n_state = S_WRITE;
                end
            end

            S_WRITE: begin
                if (r_new_ins) begin
                    n_valid[r_new_slot] = 1'b1;
                    n_count             = r_count + CNTW'(1);
                end
                n_state = S_RESP;
            end

            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_rsp;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rd_live   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_rd_live   <= w_ren;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_cnt        <= n_cnt;
        r_rd_idx     <= r_cnt[IW-1:0];
        r_hit_found  <= n_hit_found;
        r_hit_idx    <= n_hit_idx;
        r_hit_pin    <= n_hit_pin;
        r_hit_dirty  <= n_hit_dirty;
        r_hit_age    <= n_hit_age;
        r_vic_found  <= n_vic_found;
        r_vic_idx    <= n_vic_idx;
        r_vic_age    <= n_vic_age;
        r_vic_tag    <= n_vic_tag;
        r_vic_dirty  <= n_vic_dirty;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_drop_s     <= n_drop_s;
        r_drop_r     <= n_drop_r;
        r_new_slot   <= n_new_slot;
        r_new_entry  <= n_new_entry;
        r_new_ins    <= n_new_ins;
        r_rsp        <= n_rsp;
        r_out        <= n_out;
    end

    // occupancy counter tracks the valid bits
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("occupancy count out of step with valid bits");

    // an eviction is only reported with a successful insert
    a_evict_inserts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.evicted_valid |-> r_out.status == ST_INSERTED)
        else $error("eviction reported without insert");

    // writeback only for an evicted frame
    a_wb_evicted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.writeback |-> r_out.evicted_valid)
        else $error("writeback without eviction");

    // rank shift never touches the frame that was dropped
    a_drop_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DROP) && w_wen |-> r_rd_idx != r_drop_s)
        else $error("rank shift hit the dropped frame");

endmodule
